/* rtl/vsf_pkg.sv */
// Shared types and constants of the VLAN-aware IPv4 source address filter.
package vsf_pkg;

  localparam int QueueSlotsDef = 64;
  localparam int TagDepthDef   = 2;

  localparam int PosW   = 6;
  localparam int QueueW = 8;
  localparam int MaskW  = 64;
  localparam int AddrW  = 32;
  localparam int CfgW   = 64;

  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [15:0] ETYPE_8021Q  = 16'h8100;
  localparam logic [15:0] ETYPE_8021AD = 16'h88A8;

  // Byte offsets within the frame and within the IPv4 header.
  localparam logic [PosW-1:0] FIRST_TYPE_END = 6'd13;
  localparam logic [PosW:0]   SRC_FIRST      = 7'd12;
  localparam logic [PosW:0]   SRC_LAST       = 7'd15;
  localparam logic [PosW:0]   HDR_LAST       = 7'd19;
  localparam logic [PosW-1:0] POS_MAX        = 6'd63;

  // Parse status codes.
  localparam logic [1:0] ST_UNDECIDED = 2'd0;
  localparam logic [1:0] ST_IPV4      = 2'd1;
  localparam logic [1:0] ST_REJECTED  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_TARGET = 1'b0;
  localparam logic CFG_MASK   = 1'b1;

  typedef struct packed {
    logic [7:0]        data;
    logic              last;
    logic [QueueW-1:0] queue;
  } beat_t;

  typedef struct packed {
    logic              verdict;
    logic [QueueW-1:0] queue;
  } result_t;

endpackage

/* rtl/vlan_ipv4_source_filter.sv */
// Top level of the VLAN-aware IPv4 source address filter.
// Usage:
// The slave stream takes one frame byte per beat: tdata is the byte, tlast marks the
// final byte and tuser carries the receive queue number. For every frame the master
// stream gives exactly one beat, when the last byte has been parsed: tuser is the
// verdict (1 redirect, 0 pass) and tdata the queue number sent with the last byte.
// The parser skips up to TAG_DEPTH VLAN tags, needs an IPv4 EtherType and a whole
// 20-byte header, and redirects when the source address matches the target register
// and the queue is below QUEUE_SLOTS with its socket mask bit set.
// Throughput is one byte per cycle while tready is high; each byte passes an input
// register and the parser logic, and a last byte's verdict then waits in the result
// register until the master side takes it.
// While a verdict waits for tready, non-last bytes keep flowing; a second last byte
// waits in the input register, and tready drops only when that register is full.
// Reset clears both registers' valid flags, the parser state and the configuration
// registers. Configuration writes are taken through cfg_we_i at any clock edge and
// should be made while no frame is in flight.
module vlan_ipv4_source_filter #(
  parameter int QUEUE_SLOTS = vsf_pkg::QueueSlotsDef,
  parameter int TAG_DEPTH   = vsf_pkg::TagDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [7:0]                 s_axis_tdata_i,   // [7:0] data_byte
  input  logic                       s_axis_tlast_i,
  input  logic [7:0]                 s_axis_tuser_i,   // [7:0] rx_queue
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [7:0]                 m_axis_tdata_o,   // [7:0] target_queue
  output logic                       m_axis_tuser_o,   // [0] verdict
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [vsf_pkg::CfgW-1:0]   cfg_data_i
);

  logic [vsf_pkg::AddrW-1:0] target_q;
  logic [vsf_pkg::MaskW-1:0] mask_q;

  vsf_pkg::beat_t   in_beat;
  vsf_pkg::beat_t   beat;
  vsf_pkg::result_t result;
  vsf_pkg::result_t out_result;
  logic             beat_valid;
  logic             out_ready;
  logic             pop;
  logic             load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      mask_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vsf_pkg::CFG_TARGET: target_q <= cfg_data_i[vsf_pkg::AddrW-1:0];
        vsf_pkg::CFG_MASK:   mask_q   <= cfg_data_i[vsf_pkg::MaskW-1:0];
        default: ;
      endcase
    end
  end

  assign in_beat.data  = s_axis_tdata_i;
  assign in_beat.last  = s_axis_tlast_i;
  assign in_beat.queue = s_axis_tuser_i;

  // A held byte moves on unless it is a last byte and the result register is busy.
  assign pop  = beat_valid && (!beat.last || out_ready);
  assign load = pop && beat.last;

  vsf_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_beat_i    (in_beat),
    .beat_valid_o (beat_valid),
    .beat_o       (beat),
    .pop_i        (pop)
  );

  vsf_parser #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .TAG_DEPTH   (TAG_DEPTH)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pop_i    (pop),
    .beat_i   (beat),
    .target_i (target_q),
    .mask_i   (mask_q),
    .result_o (result)
  );

  vsf_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .result_i    (result),
    .ready_o     (out_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (out_result)
  );

  assign m_axis_tdata_o = out_result.queue;
  assign m_axis_tuser_o = out_result.verdict;

`ifndef NO_ASSERTIONS
  // A new verdict appears only after a last byte left the input register.
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(pop && beat.last))
    else $error("verdict beat without a last byte");

  // A redirect always refers to a queue in range.
  a_redirect_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o < 8'(QUEUE_SLOTS)))
    else $error("redirect to a queue out of range");

  // A redirect needs a bound socket on its queue.
  a_redirect_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> mask_q[m_axis_tdata_o[5:0]])
    else $error("redirect to a queue without a socket");

  // A last byte never overwrites a verdict that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !load)
    else $error("pending verdict overwritten");
`endif

endmodule

/* rtl/vsf_in_stage.sv */
// Input register stage that holds one received beat until the parser takes it.
module vsf_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vsf_pkg::beat_t in_beat_i,
  output logic          beat_valid_o,
  output vsf_pkg::beat_t beat_o,
  input  logic          pop_i
);

  logic           valid_q, valid_d;
  vsf_pkg::beat_t beat_q;
  logic           load;

  assign in_ready_o = !valid_q || pop_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= in_beat_i;
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o       = beat_q;

endmodule

/* rtl/vsf_parser.sv */
// Per-frame header parser: tag skipping, IPv4 detection, source capture and verdict.
module vsf_parser #(
  parameter int QUEUE_SLOTS = vsf_pkg::QueueSlotsDef,
  parameter int TAG_DEPTH   = vsf_pkg::TagDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_i,
  input  vsf_pkg::beat_t                beat_i,
  input  logic [vsf_pkg::AddrW-1:0]     target_i,
  input  logic [vsf_pkg::MaskW-1:0]     mask_i,
  output vsf_pkg::result_t              result_o
);

  localparam int TagW = (TAG_DEPTH > 0) ? $clog2(TAG_DEPTH + 1) : 1;
  localparam int PosW = vsf_pkg::PosW;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [15:0]      proto_q, proto_d;
  logic [TagW-1:0]  tags_q, tags_d;
  logic [PosW-1:0]  hdr_q, hdr_d;
  logic [31:0]      addr_q, addr_d;
  logic [1:0]       status_q, status_d;

  logic [PosW-1:0]  type_pos;
  logic [PosW:0]    pos_x;
  logic [PosW:0]    hdr_x;
  logic             is_tag;
  logic             redirect;

  assign type_pos = vsf_pkg::FIRST_TYPE_END + PosW'({tags_q, 2'b00});
  assign pos_x    = {1'b0, pos_q};
  assign hdr_x    = {1'b0, hdr_d};
  assign is_tag   = (proto_d == vsf_pkg::ETYPE_8021Q) || (proto_d == vsf_pkg::ETYPE_8021AD);

  always_comb begin
    proto_d  = proto_q;
    tags_d   = tags_q;
    hdr_d    = hdr_q;
    addr_d   = addr_q;
    status_d = status_q;
    case (status_q)
      vsf_pkg::ST_UNDECIDED: begin
        proto_d = {proto_q[7:0], beat_i.data};
        if (pos_q == type_pos) begin
          if (is_tag && (tags_q < TagW'(TAG_DEPTH))) begin
            tags_d = tags_q + 1'b1;
          end else if (proto_d == vsf_pkg::ETYPE_IPV4) begin
            hdr_d    = pos_q + 1'b1;
            status_d = vsf_pkg::ST_IPV4;
          end else begin
            status_d = vsf_pkg::ST_REJECTED;
          end
        end
      end
      vsf_pkg::ST_IPV4: begin
        if ((pos_x >= {1'b0, hdr_q} + vsf_pkg::SRC_FIRST) &&
            (pos_x <= {1'b0, hdr_q} + vsf_pkg::SRC_LAST)) begin
          addr_d = {addr_q[23:0], beat_i.data};
        end
      end
      default: ;
    endcase
  end

  // The verdict looks at the state as it stands after this byte.
  always_comb begin
    redirect = 1'b0;
    if ((status_d == vsf_pkg::ST_IPV4) && (pos_x >= hdr_x + vsf_pkg::HDR_LAST) &&
        (addr_d == target_i) && (beat_i.queue < vsf_pkg::QueueW'(QUEUE_SLOTS))) begin
      redirect = mask_i[beat_i.queue[5:0]];
    end
  end

  assign result_o.verdict = redirect;
  assign result_o.queue   = beat_i.queue;

  always_comb begin
    pos_d = pos_q;
    if (pos_q < vsf_pkg::POS_MAX) begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      proto_q  <= '0;
      tags_q   <= '0;
      hdr_q    <= '0;
      addr_q   <= '0;
      status_q <= vsf_pkg::ST_UNDECIDED;
    end else if (pop_i) begin
      if (beat_i.last) begin
        pos_q    <= '0;
        proto_q  <= '0;
        tags_q   <= '0;
        hdr_q    <= '0;
        addr_q   <= '0;
        status_q <= vsf_pkg::ST_UNDECIDED;
      end else begin
        pos_q    <= pos_d;
        proto_q  <= proto_d;
        tags_q   <= tags_d;
        hdr_q    <= hdr_d;
        addr_q   <= addr_d;
        status_q <= status_d;
      end
    end
  end

endmodule

/* rtl/vsf_out_stage.sv */
// Result register that holds one verdict until the receiver takes it.
module vsf_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  vsf_pkg::result_t result_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output vsf_pkg::result_t result_o
);

  logic             valid_q;
  vsf_pkg::result_t result_q;

  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

/* verif/vsf_checker.sv */
// Checker for the VLAN-aware IPv4 source filter: predicts each frame verdict and compares it.
module vsf_checker
  import vsf_pkg::*;
#(
  parameter int QUEUE_SLOTS = QueueSlotsDef,
  parameter int TAG_DEPTH   = TagDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  input  logic            s_ready_i,
  input  logic [7:0]      s_data_i,
  input  logic            s_last_i,
  input  logic [7:0]      s_user_i,
  input  logic            m_valid_i,
  input  logic            m_ready_i,
  input  logic [7:0]      m_data_i,
  input  logic            m_user_i,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output int              fail_count_o,
  output int              verdicts_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [AddrW-1:0] target_addr;
  logic [MaskW-1:0] socket_mask;

  logic [PosW-1:0]  byte_idx;
  logic [15:0]      type_shift;
  int               tags_skipped;
  logic [PosW-1:0]  ip_start;
  logic [AddrW-1:0] src_shift;
  logic [1:0]       parse_st;

  result_t          expected_verdicts[$];
  int               mismatches;

  task automatic clear_frame();
    byte_idx     = '0;
    type_shift   = '0;
    tags_skipped = 0;
    ip_start     = '0;
    src_shift    = '0;
    parse_st     = ST_UNDECIDED;
  endtask

  // Advances the frame parser by one byte and queues a verdict on the last byte.
  task automatic parse_byte(input logic [7:0] b, input logic last, input logic [7:0] q);
    int      p;
    logic    redirect;
    result_t res;
    p = int'(byte_idx);
    if (parse_st == ST_UNDECIDED) begin
      type_shift = {type_shift[7:0], b};
      if (p == int'(FIRST_TYPE_END) + 4 * tags_skipped) begin
        if ((type_shift == ETYPE_8021Q || type_shift == ETYPE_8021AD) &&
            tags_skipped < TAG_DEPTH) begin
          tags_skipped++;
        end else if (type_shift == ETYPE_IPV4) begin
          ip_start = byte_idx + 6'd1;
          parse_st = ST_IPV4;
        end else begin
          parse_st = ST_REJECTED;
        end
      end
    end else if (parse_st == ST_IPV4) begin
      if (p >= int'(ip_start) + int'(SRC_FIRST) && p <= int'(ip_start) + int'(SRC_LAST)) begin
        src_shift = {src_shift[23:0], b};
      end
    end
    if (byte_idx < POS_MAX) byte_idx = byte_idx + 6'd1;
    if (last) begin
      redirect = 1'b0;
      if (parse_st == ST_IPV4 && p >= int'(ip_start) + int'(HDR_LAST) &&
          src_shift == target_addr && int'(q) < QUEUE_SLOTS) begin
        redirect = socket_mask[q[5:0]];
      end
      res.verdict = redirect;
      res.queue   = q;
      expected_verdicts.push_back(res);
      clear_frame();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_res;
    if (!rst_ni) begin
      target_addr = '0;
      socket_mask = '0;
      clear_frame();
      expected_verdicts.delete();
      mismatches = 0;
      fail_count_o       <= 0;
      verdicts_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TARGET: target_addr = cfg_data_i[AddrW-1:0];
          CFG_MASK:   socket_mask = cfg_data_i[MaskW-1:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) parse_byte(s_data_i, s_last_i, s_user_i);
      if (m_valid_i && m_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          $display("%0t: verdict beat with none expected: got verdict %0d queue %0d",
                   $time, m_user_i, m_data_i);
        end else begin
          exp_res = expected_verdicts.pop_front();
          if (exp_res.verdict !== m_user_i) begin
            mismatches++;
            $display("%0t: verdict mismatch: expected %0d, got %0d (queue %0d)",
                     $time, exp_res.verdict, m_user_i, exp_res.queue);
          end
          if (exp_res.queue !== m_data_i) begin
            mismatches++;
            $display("%0t: queue mismatch: expected %0d, got %0d",
                     $time, exp_res.queue, m_data_i);
          end
        end
      end
      fail_count_o       <= mismatches;
      verdicts_pending_o <= expected_verdicts.size();
    end
  end

endmodule

/* verif/tb_vlan_ipv4_source_filter.sv */
// Testbench top for the VLAN-aware IPv4 source filter: frame stimulus, stalls and verdict.
module tb_vlan_ipv4_source_filter;
  import vsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam time         CLK_PERIOD   = 10ns;
  localparam int          RESET_CYCLES = 8;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          HOLD_CYCLES  = 200;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic            clk_i           = 1'b0;
  logic            rst_ni          = 1'b0;
  logic            s_axis_tvalid_i = 1'b0;
  logic            s_axis_tready_o;
  logic [7:0]      s_axis_tdata_i  = '0;   // [7:0] data_byte
  logic            s_axis_tlast_i  = 1'b0;
  logic [7:0]      s_axis_tuser_i  = '0;   // [7:0] rx_queue
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i = 1'b0;
  logic [7:0]      m_axis_tdata_o;         // [7:0] target_queue
  logic            m_axis_tuser_o;         // [0] verdict
  logic            cfg_we_i        = 1'b0;
  logic            cfg_index_i     = CFG_TARGET;
  logic [CfgW-1:0] cfg_data_i      = '0;

  int              fail_count;
  int              verdicts_pending;
  int unsigned     cycle_cnt = 0;

  logic [7:0]      frame_bytes[$];
  logic [AddrW-1:0] cur_target = '0;
  bit              tx_idle_on  = 1'b1;
  bit              rx_idle_on  = 1'b1;
  bit              rx_hold_req = 1'b0;
  int              phase_bytes;
  int              phase_frames;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  vlan_ipv4_source_filter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  vsf_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .s_valid_i          (s_axis_tvalid_i),
    .s_ready_i          (s_axis_tready_o),
    .s_data_i           (s_axis_tdata_i),
    .s_last_i           (s_axis_tlast_i),
    .s_user_i           (s_axis_tuser_i),
    .m_valid_i          (m_axis_tvalid_o),
    .m_ready_i          (m_axis_tready_i),
    .m_data_i           (m_axis_tdata_o),
    .m_user_i           (m_axis_tuser_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .fail_count_o       (fail_count),
    .verdicts_pending_o (verdicts_pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** vlan_ipv4_source_filter: FAILED **");
      $finish;
    end
  end

  // Verdict receiver; a requested hold keeps tready low long enough to back up the input.
  initial begin
    int w;
    wait (rst_ni);
    forever begin
      if (rx_hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) rx_idle_on = !rx_idle_on;
      w = rx_idle_on ? $urandom_range(0, 7) : 0;
      if (w > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input logic [7:0] q);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    s_axis_tuser_i  <= q;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Only the queue number on the last byte counts; the others carry noise.
  task automatic send_frame(input logic [7:0] q);
    int n;
    n = frame_bytes.size();
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) send_byte(frame_bytes[i], 1'b1, q);
      else            send_byte(frame_bytes[i], 1'b0, 8'($urandom_range(0, 255)));
    end
    phase_bytes  += n;
    phase_frames++;
  endtask

  task automatic add_random(input int n);
    repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic trim_frame(input int n);
    while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
  endtask

  task automatic build_ipv4(input int ntags, input logic [AddrW-1:0] src, input int payload);
    logic [15:0] tag_type;
    frame_bytes.delete();
    add_random(12);
    for (int t = 0; t < ntags; t++) begin
      tag_type = $urandom_range(0, 1) ? ETYPE_8021Q : ETYPE_8021AD;
      frame_bytes.push_back(tag_type[15:8]);
      frame_bytes.push_back(tag_type[7:0]);
      add_random(2);
    end
    frame_bytes.push_back(ETYPE_IPV4[15:8]);
    frame_bytes.push_back(ETYPE_IPV4[7:0]);
    add_random(12);
    for (int k = 3; k >= 0; k--) frame_bytes.push_back(src[8*k +: 8]);
    add_random(4 + payload);
  endtask

  // Idle: stop offering bytes and wait until every verdict has come out.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (verdicts_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [AddrW-1:0] target, input logic [MaskW-1:0] mask);
    cur_target = target;
    cfg_write(CFG_TARGET, CfgW'(target));
    cfg_write(CFG_MASK, CfgW'(mask));
  endtask

  function automatic logic [7:0] pick_queue();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7)  return 8'($urandom_range(0, 63));
    if (r < 9)  return 8'($urandom_range(64, 255));
    return $urandom_range(0, 1) ? 8'd63 : 8'd64;
  endfunction

  function automatic logic [AddrW-1:0] pick_source();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return cur_target;
    if (r < 9) return cur_target ^ (32'd1 << $urandom_range(0, 31));
    return AddrW'($urandom);
  endfunction

  task automatic random_frame();
    int r;
    int ntags;
    int idx;
    if ($urandom_range(0, 15) == 0) tx_idle_on = !tx_idle_on;
    r     = $urandom_range(0, 99);
    ntags = $urandom_range(0, 2);
    if (r < 60) begin
      build_ipv4(ntags, pick_source(), $urandom_range(0, 6));
    end else if (r < 70) begin
      // Trimmed to a random length, which may end before or inside the IPv4 header.
      build_ipv4(ntags, cur_target, $urandom_range(0, 2));
      trim_frame($urandom_range(1, frame_bytes.size()));
    end else if (r < 78) begin
      build_ipv4(ntags, cur_target, $urandom_range(0, 4));
      idx = 12 + 4 * ntags;
      frame_bytes[idx]     = 8'($urandom_range(0, 255));
      frame_bytes[idx + 1] = 8'($urandom_range(0, 255));
    end else if (r < 84) begin
      build_ipv4(3, cur_target, $urandom_range(0, 4));
    end else if (r < 88) begin
      // Long enough for the byte counter to saturate.
      build_ipv4(ntags, pick_source(), $urandom_range(30, 50));
    end else begin
      frame_bytes.delete();
      add_random($urandom_range(1, 40));
    end
    send_frame(pick_queue());
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register reset values: nothing can be redirected.
    frame_bytes = {8'hFF};
    send_frame(8'd255);
    build_ipv4(0, '0, 0);
    send_frame(8'd0);
    frame_bytes = {8'h00};
    send_frame(8'd0);
    wait_idle();

    set_config(AddrW'($urandom), '1);
    build_ipv4(0, cur_target, 0);
    send_frame(8'd0);
    build_ipv4(2, cur_target, 1);
    send_frame(8'd63);
    build_ipv4(1, cur_target, 0);
    send_frame(8'd64);
    build_ipv4(3, cur_target, 0);
    send_frame(8'd1);
    build_ipv4(0, cur_target, 0);
    trim_frame(33);
    send_frame(8'd2);
    build_ipv4(0, cur_target, 0);
    trim_frame(14);
    send_frame(8'd3);
    build_ipv4(0, ~cur_target, 2);
    send_frame(8'd4);
    build_ipv4(1, cur_target, 40);
    send_frame(8'd5);

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0:       set_config('1, {$urandom, $urandom});
        1:       set_config('0, 64'h8000_0000_0000_0001);
        2:       set_config(AddrW'($urandom), {$urandom, $urandom});
        default: set_config(AddrW'($urandom), '1);
      endcase
      phase_bytes  = 0;
      phase_frames = 0;
      while (phase_bytes < 160 || phase_frames < 4) begin
        if (ph == 1 && phase_frames == 3) wait_idle();
        if (ph == 2 && phase_frames == 3) begin
          // Verdicts back up behind a long hold while short frames keep coming.
          rx_hold_req = 1'b1;
          tx_idle_on  = 1'b0;
          repeat (12) begin
            frame_bytes.delete();
            add_random($urandom_range(1, 3));
            send_frame(pick_queue());
          end
        end
        random_frame();
      end
    end

    wait_idle();
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("** vlan_ipv4_source_filter: PASSED **");
    end else begin
      $display("** vlan_ipv4_source_filter: FAILED **");
    end
    $finish;
  end

endmodule
